@@ design/conv2d_pkg.sv @@
// shared types, constants and helpers for the valid-mode 2d convolution block
package conv2d_pkg;

    localparam int MAX_IMAGE_DIM  = 64;
    localparam int MAX_KERNEL_DIM = 16;

    localparam int IMG_DIM_W  = $clog2(MAX_IMAGE_DIM);
    localparam int KER_DIM_W  = $clog2(MAX_KERNEL_DIM);
    localparam int IMG_DEPTH  = MAX_IMAGE_DIM * MAX_IMAGE_DIM;
    localparam int KER_DEPTH  = MAX_KERNEL_DIM * MAX_KERNEL_DIM;
    localparam int IMG_ADDR_W = 2 * IMG_DIM_W;
    localparam int KER_ADDR_W = 2 * KER_DIM_W;

    localparam int DATA_W     = 32;
    localparam int POS_W      = 6;
    localparam int IMG_CFG_W  = 7;
    localparam int KER_CFG_W  = 5;
    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 2;

    typedef enum logic [1:0] {
        FUNC_WR_IMAGE  = 2'd0,
        FUNC_WR_KERNEL = 2'd1,
        FUNC_COMPUTE   = 2'd2,
        FUNC_UNUSED    = 2'd3
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_ROWS  = 2'd0,
        REG_IMAGE_COLS  = 2'd1,
        REG_KERNEL_ROWS = 2'd2,
        REG_KERNEL_COLS = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [1:0]              func;
        logic [POS_W-1:0]        row;
        logic [POS_W-1:0]        col;
        logic signed [DATA_W-1:0] value;
    } in_beat_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] conv_value;
        logic                     bad_position;
    } out_beat_t;

    function automatic logic [IMG_CFG_W-1:0] clamp_img(input logic [IMG_CFG_W-1:0] v);
        if (v > IMG_CFG_W'(MAX_IMAGE_DIM)) begin
            return IMG_CFG_W'(MAX_IMAGE_DIM);
        end
        return v;
    endfunction

    function automatic logic [KER_CFG_W-1:0] clamp_ker(input logic [KER_CFG_W-1:0] v);
        if (v > KER_CFG_W'(MAX_KERNEL_DIM)) begin
            return KER_CFG_W'(MAX_KERNEL_DIM);
        end
        return v;
    endfunction

endpackage

@@ design/conv2d_ram.sv @@
// generic single-write, single-read ram with registered read data
module conv2d_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/conv2d_valid_int32.sv @@
// top level of the valid-mode 2d convolution block with image and kernel rams
// Image and kernel writes are accepted whenever no request is being worked
// on. A compute request walks the kernel one element per cycle through a
// single shared multiplier, reading one image word and one kernel word per
// cycle; a request outside the output area, or with an empty kernel, goes
// straight to the finish state. A finished result sits in an output register,
// so writes keep being accepted while it waits to be taken. Neither ram is
// cleared after reset.
module conv2d_valid_int32 (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  conv2d_pkg::in_beat_t                 s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output conv2d_pkg::out_beat_t                m_data,
    input  logic                                 cfg_we,
    input  logic [conv2d_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [conv2d_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int IW = conv2d_pkg::IMG_DIM_W;
    localparam int KW = conv2d_pkg::KER_DIM_W;
    localparam int IC = conv2d_pkg::IMG_CFG_W;
    localparam int KC = conv2d_pkg::KER_CFG_W;
    localparam int DW = conv2d_pkg::DATA_W;
    localparam int PW = conv2d_pkg::POS_W;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_RUN    = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [IC-1:0] image_rows_reg, image_cols_reg;
    logic [KC-1:0] kernel_rows_reg, kernel_cols_reg;

    logic [PW-1:0] row_reg, row_next;
    logic [PW-1:0] col_reg, col_next;
    logic [KC-1:0] kr_reg, kr_next;
    logic [KC-1:0] kc_reg, kc_next;
    logic [KW-1:0] k_reg, k_next;
    logic [KW-1:0] l_reg, l_next;
    logic [DW-1:0] acc_reg, acc_next;
    logic          bad_reg, bad_next;
    logic [DW-1:0] prod_reg, prod_next;
    logic          p1_valid_reg, p1_last_reg;
    logic          p2_valid_reg, p2_last_reg;
    logic          m_valid_reg, m_valid_next;
    conv2d_pkg::out_beat_t m_data_reg, m_data_next;

    logic          in_fire;
    logic          out_free;
    logic          issue_last;
    logic [IC-1:0] ir, ic;
    logic [KC-1:0] kr, kc;
    logic [IC-1:0] row_end, col_end;
    logic          req_bad;

    logic                                img_we;
    logic [conv2d_pkg::IMG_ADDR_W-1:0]   img_waddr, img_raddr;
    logic [DW-1:0]                       img_rdata;
    logic                                ker_we;
    logic [conv2d_pkg::KER_ADDR_W-1:0]   ker_waddr, ker_raddr;
    logic [DW-1:0]                       ker_rdata;
    logic [PW-1:0]                       img_r, img_c;
    logic [KC-1:0]                       ker_r_full, ker_c_full;

    assign s_ready  = (state_reg == ST_IDLE);
    assign in_fire  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_rows_reg  <= IC'(1);
            image_cols_reg  <= IC'(1);
            kernel_rows_reg <= KC'(1);
            kernel_cols_reg <= KC'(1);
        end else if (cfg_we) begin
            unique case (conv2d_pkg::cfg_reg_t'(cfg_index))
                conv2d_pkg::REG_IMAGE_ROWS:  image_rows_reg  <= cfg_wdata[IC-1:0];
                conv2d_pkg::REG_IMAGE_COLS:  image_cols_reg  <= cfg_wdata[IC-1:0];
                conv2d_pkg::REG_KERNEL_ROWS: kernel_rows_reg <= cfg_wdata[KC-1:0];
                conv2d_pkg::REG_KERNEL_COLS: kernel_cols_reg <= cfg_wdata[KC-1:0];
                default: ;
            endcase
        end
    end

    // request checks
    assign ir      = conv2d_pkg::clamp_img(image_rows_reg);
    assign ic      = conv2d_pkg::clamp_img(image_cols_reg);
    assign kr      = conv2d_pkg::clamp_ker(kernel_rows_reg);
    assign kc      = conv2d_pkg::clamp_ker(kernel_cols_reg);
    assign row_end = IC'(s_data.row) + IC'(kr);
    assign col_end = IC'(s_data.col) + IC'(kc);
    assign req_bad = (row_end > ir) || (col_end > ic) || (ir == '0) || (ic == '0);

    // ram write ports
    assign img_we    = in_fire && (s_data.func == conv2d_pkg::FUNC_WR_IMAGE)
                       && (IC'(s_data.row) < IC'(conv2d_pkg::MAX_IMAGE_DIM))
                       && (IC'(s_data.col) < IC'(conv2d_pkg::MAX_IMAGE_DIM));
    assign img_waddr = {s_data.row[IW-1:0], s_data.col[IW-1:0]};
    assign ker_we    = in_fire && (s_data.func == conv2d_pkg::FUNC_WR_KERNEL)
                       && (IC'(s_data.row) < IC'(conv2d_pkg::MAX_KERNEL_DIM))
                       && (IC'(s_data.col) < IC'(conv2d_pkg::MAX_KERNEL_DIM));
    assign ker_waddr = {s_data.row[KW-1:0], s_data.col[KW-1:0]};

    // ram read addresses from the kernel walk
    assign img_r      = row_reg + PW'(k_reg);
    assign img_c      = col_reg + PW'(l_reg);
    assign img_raddr  = {img_r[IW-1:0], img_c[IW-1:0]};
    assign ker_r_full = kr_reg - KC'(1) - KC'(k_reg);
    assign ker_c_full = kc_reg - KC'(1) - KC'(l_reg);
    assign ker_raddr  = {ker_r_full[KW-1:0], ker_c_full[KW-1:0]};

    assign issue_last = (KC'(k_reg) == kr_reg - KC'(1)) && (KC'(l_reg) == kc_reg - KC'(1));

    conv2d_ram #(
        .WIDTH (DW),
        .DEPTH (conv2d_pkg::IMG_DEPTH)
    ) u_image_ram (
        .aclk  (aclk),
        .we    (img_we),
        .waddr (img_waddr),
        .wdata (s_data.value),
        .raddr (img_raddr),
        .rdata (img_rdata)
    );

    conv2d_ram #(
        .WIDTH (DW),
        .DEPTH (conv2d_pkg::KER_DEPTH)
    ) u_kernel_ram (
        .aclk  (aclk),
        .we    (ker_we),
        .waddr (ker_waddr),
        .wdata (s_data.value),
        .raddr (ker_raddr),
        .rdata (ker_rdata)
    );

    assign prod_next = DW'(img_rdata * ker_rdata);

    always_comb begin
        state_next   = state_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        kr_next      = kr_reg;
        kc_next      = kc_reg;
        k_next       = k_reg;
        l_next       = l_reg;
        acc_next     = acc_reg;
        bad_next     = bad_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (p2_valid_reg) begin
            acc_next = acc_reg + prod_reg;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire && (s_data.func == conv2d_pkg::FUNC_COMPUTE)) begin
                    row_next = s_data.row;
                    col_next = s_data.col;
                    kr_next  = kr;
                    kc_next  = kc;
                    k_next   = '0;
                    l_next   = '0;
                    acc_next = '0;
                    bad_next = req_bad;
                    if (req_bad || (kr == '0) || (kc == '0)) begin
                        state_next = ST_FINISH;
                    end else begin
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                if (KC'(l_reg) == kc_reg - KC'(1)) begin
                    l_next = '0;
                    k_next = k_reg + KW'(1);
                end else begin
                    l_next = l_reg + KW'(1);
                end
                if (issue_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (p2_valid_reg && p2_last_reg) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_valid_next             = 1'b1;
                    m_data_next.conv_value   = bad_reg ? '0 : acc_reg;
                    m_data_next.bad_position = bad_reg;
                    state_next               = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_valid_reg  <= m_valid_next;
            p1_valid_reg <= (state_reg == ST_RUN);
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        row_reg     <= row_next;
        col_reg     <= col_next;
        kr_reg      <= kr_next;
        kc_reg      <= kc_next;
        k_reg       <= k_next;
        l_reg       <= l_next;
        acc_reg     <= acc_next;
        bad_reg     <= bad_next;
        prod_reg    <= prod_next;
        p1_last_reg <= (state_reg == ST_RUN) && issue_last;
        p2_last_reg <= p1_last_reg;
        m_data_reg  <= m_data_next;
    end

endmodule
